// ----- rtl/mrc_pkg.sv -----
// Shared widths, types and constants of the MRC combiner and 16-QAM slicer.
package mrc_pkg;

    localparam int CHAN_W    = 10;
    localparam int SAMPLE_W  = 20;
    localparam int LEVEL_W   = 3;
    localparam int BITS_W    = 4;
    localparam int SUM_W     = 34;
    localparam int ENERGY_W  = 22;
    localparam int PROD_W    = CHAN_W + SAMPLE_W;
    localparam int TERM_W    = PROD_W + 1;
    localparam int SQ_W      = 2 * CHAN_W;
    localparam int ETERM_W   = SQ_W;

    typedef logic signed [CHAN_W-1:0]   t_chan;
    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [LEVEL_W-1:0]         t_level;
    typedef logic [BITS_W-1:0]          t_bits;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic [ENERGY_W-1:0]        t_energy;

    localparam t_level  LEVEL_RESET = 3'd2;
    localparam t_sum    SUM_MAX     = {1'b0, {(SUM_W - 1){1'b1}}};
    localparam t_sum    SUM_MIN     = {1'b1, {(SUM_W - 1){1'b0}}};
    localparam t_energy ENERGY_MAX  = {ENERGY_W{1'b1}};

endpackage

// ----- rtl/mrc_in_if.sv -----
// Input channel: one antenna's channel estimate and received sample per request.
interface mrc_in_if;
    logic             valid;
    logic             ready;
    mrc_pkg::t_chan   chan_re;
    mrc_pkg::t_chan   chan_im;
    mrc_pkg::t_sample sample_re;
    mrc_pkg::t_sample sample_im;
    logic             last_antenna;

    modport source (
        output valid, chan_re, chan_im, sample_re, sample_im, last_antenna,
        input  ready
    );
    modport sink (
        input  valid, chan_re, chan_im, sample_re, sample_im, last_antenna,
        output ready
    );
endinterface

// ----- rtl/mrc_out_if.sv -----
// Output channel: one decided 16-QAM symbol per request.
interface mrc_out_if;
    logic           valid;
    logic           ready;
    mrc_pkg::t_bits symbol_bits;
    logic           no_channel;

    modport source (output valid, symbol_bits, no_channel, input ready);
    modport sink (input valid, symbol_bits, no_channel, output ready);
endinterface

// ----- rtl/mrc_combiner_16qam_slicer.sv -----
// Top level: maximal-ratio combiner over antennas with a hard 16-QAM decision.
//
// Each request on i_in carries one antenna's channel estimate and received
// sample. The block accumulates conj(h)*y and |h|^2 over the antennas of one
// symbol. A request with last_antenna set closes the symbol: one request
// appears on o_out with the four Gray bits, and the accumulators clear.
// Requests without last_antenna produce nothing on o_out.
// The user writes the decision level through i_cfg_we and i_cfg_data only
// while idle; the block does not enforce this. One request is accepted
// every cycle while i_in.ready is high. The path is four register stages:
// input, products, accumulation, decision, which a result passes in order.
// The output register is backed by a skid register, so a stalled result
// does not stop input; i_in.ready falls only when both hold results, and
// the whole pipeline then holds until o_out takes one.
// Synchronous reset clears the accumulators, empties the pipeline and sets
// the decision level to 2. Zero channel energy gives bits 0000 with
// no_channel set.
module mrc_combiner_16qam_slicer #(
    parameter int FRAC_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  mrc_pkg::t_level        i_cfg_data,
    mrc_in_if.sink                 i_in,
    mrc_out_if.source              o_out
);

    localparam int SCALED_W = mrc_pkg::LEVEL_W + mrc_pkg::ENERGY_W;
    localparam int TH_W     = SCALED_W + FRAC_BITS;
    localparam int CMP_W    = (TH_W > mrc_pkg::SUM_W) ? TH_W : mrc_pkg::SUM_W;

    function automatic logic [mrc_pkg::SUM_W-1:0] magnitude(input mrc_pkg::t_sum v);
        logic [mrc_pkg::SUM_W-1:0] m;
        m = v[mrc_pkg::SUM_W-1] ? (~v + 1'b1) : v;
        return m;
    endfunction

    logic w_adv;

    mrc_pkg::t_level r_level;

    logic             r_s1_valid;
    mrc_pkg::t_chan   r_chan_re;
    mrc_pkg::t_chan   r_chan_im;
    mrc_pkg::t_sample r_sample_re;
    mrc_pkg::t_sample r_sample_im;
    logic             r_s1_last;

    logic signed [mrc_pkg::PROD_W-1:0] w_prod_rr;
    logic signed [mrc_pkg::PROD_W-1:0] w_prod_ii;
    logic signed [mrc_pkg::PROD_W-1:0] w_prod_ri;
    logic signed [mrc_pkg::PROD_W-1:0] w_prod_ir;
    logic signed [mrc_pkg::SQ_W-1:0]   w_sq_re;
    logic signed [mrc_pkg::SQ_W-1:0]   w_sq_im;

    logic                               r_s2_valid;
    logic signed [mrc_pkg::TERM_W-1:0]  r_term_re;
    logic signed [mrc_pkg::TERM_W-1:0]  r_term_im;
    logic [mrc_pkg::ETERM_W-1:0]        r_term_e;
    logic                               r_s2_last;

    mrc_pkg::t_sum    r_sum_real;
    mrc_pkg::t_sum    r_sum_imag;
    mrc_pkg::t_energy r_energy_sum;
    logic signed [mrc_pkg::SUM_W:0] w_wide_re;
    logic signed [mrc_pkg::SUM_W:0] w_wide_im;
    logic [mrc_pkg::ENERGY_W:0]     w_wide_e;
    mrc_pkg::t_sum    n_sum_real;
    mrc_pkg::t_sum    n_sum_imag;
    mrc_pkg::t_energy n_energy_sum;

    logic             r_dec_valid;
    mrc_pkg::t_sum    r_dec_re;
    mrc_pkg::t_sum    r_dec_im;
    mrc_pkg::t_energy r_dec_energy;

    logic [SCALED_W-1:0] w_scaled;
    logic [CMP_W-1:0]    w_thresh;
    logic [CMP_W-1:0]    w_mag_re;
    logic [CMP_W-1:0]    w_mag_im;
    mrc_pkg::t_bits      w_res_bits;
    logic                w_res_noch;

    logic           r_out_valid;
    mrc_pkg::t_bits r_out_bits;
    logic           r_out_noch;
    logic           r_skid_valid;
    mrc_pkg::t_bits r_skid_bits;
    logic           r_skid_noch;
    logic           w_out_take;
    logic           n_out_valid;
    logic           n_skid_valid;
    logic           w_load_out;
    logic           w_load_skid;

    // The pipeline moves whenever the skid register is free.
    assign w_adv      = !r_skid_valid;
    assign i_in.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= mrc_pkg::LEVEL_RESET;
        end else if (i_cfg_we) begin
            r_level <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_chan_re   <= i_in.chan_re;
            r_chan_im   <= i_in.chan_im;
            r_sample_re <= i_in.sample_re;
            r_sample_im <= i_in.sample_im;
            r_s1_last   <= i_in.last_antenna;
        end
    end

    assign w_prod_rr = r_chan_re * r_sample_re;
    assign w_prod_ii = r_chan_im * r_sample_im;
    assign w_prod_ri = r_chan_re * r_sample_im;
    assign w_prod_ir = r_chan_im * r_sample_re;
    assign w_sq_re   = r_chan_re * r_chan_re;
    assign w_sq_im   = r_chan_im * r_chan_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_term_re <= mrc_pkg::TERM_W'(w_prod_rr) + mrc_pkg::TERM_W'(w_prod_ii);
            r_term_im <= mrc_pkg::TERM_W'(w_prod_ri) - mrc_pkg::TERM_W'(w_prod_ir);
            r_term_e  <= mrc_pkg::ETERM_W'($unsigned(w_sq_re))
                       + mrc_pkg::ETERM_W'($unsigned(w_sq_im));
            r_s2_last <= r_s1_last;
        end
    end

    // Saturating accumulation of the combined sample and the channel energy.
    always_comb begin
        w_wide_re = (mrc_pkg::SUM_W + 1)'(r_sum_real) + (mrc_pkg::SUM_W + 1)'(r_term_re);
        w_wide_im = (mrc_pkg::SUM_W + 1)'(r_sum_imag) + (mrc_pkg::SUM_W + 1)'(r_term_im);
        w_wide_e  = {1'b0, r_energy_sum} + (mrc_pkg::ENERGY_W + 1)'(r_term_e);

        if (w_wide_re[mrc_pkg::SUM_W] != w_wide_re[mrc_pkg::SUM_W-1]) begin
            n_sum_real = w_wide_re[mrc_pkg::SUM_W] ? mrc_pkg::SUM_MIN : mrc_pkg::SUM_MAX;
        end else begin
            n_sum_real = w_wide_re[mrc_pkg::SUM_W-1:0];
        end

        if (w_wide_im[mrc_pkg::SUM_W] != w_wide_im[mrc_pkg::SUM_W-1]) begin
            n_sum_imag = w_wide_im[mrc_pkg::SUM_W] ? mrc_pkg::SUM_MIN : mrc_pkg::SUM_MAX;
        end else begin
            n_sum_imag = w_wide_im[mrc_pkg::SUM_W-1:0];
        end

        if (w_wide_e[mrc_pkg::ENERGY_W]) begin
            n_energy_sum = mrc_pkg::ENERGY_MAX;
        end else begin
            n_energy_sum = w_wide_e[mrc_pkg::ENERGY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_real   <= '0;
            r_sum_imag   <= '0;
            r_energy_sum <= '0;
            r_dec_valid  <= 1'b0;
        end else if (w_adv) begin
            r_dec_valid <= r_s2_valid && r_s2_last;
            if (r_s2_valid) begin
                if (r_s2_last) begin
                    r_sum_real   <= '0;
                    r_sum_imag   <= '0;
                    r_energy_sum <= '0;
                end else begin
                    r_sum_real   <= n_sum_real;
                    r_sum_imag   <= n_sum_imag;
                    r_energy_sum <= n_energy_sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dec_re     <= n_sum_real;
            r_dec_im     <= n_sum_imag;
            r_dec_energy <= n_energy_sum;
        end
    end

    // Decision without division: compare magnitudes with (level * energy) << FRAC_BITS.
    always_comb begin
        w_scaled = r_level * r_dec_energy;
        w_thresh = CMP_W'(w_scaled) << FRAC_BITS;
        w_mag_re = CMP_W'(magnitude(r_dec_re));
        w_mag_im = CMP_W'(magnitude(r_dec_im));
        if (r_dec_energy == '0) begin
            w_res_bits = '0;
            w_res_noch = 1'b1;
        end else begin
            w_res_bits = {r_dec_im[mrc_pkg::SUM_W-1], w_mag_im > w_thresh,
                          r_dec_re[mrc_pkg::SUM_W-1], w_mag_re > w_thresh};
            w_res_noch = 1'b0;
        end
    end

    always_comb begin
        w_out_take   = r_out_valid && o_out.ready;
        w_load_out   = 1'b0;
        w_load_skid  = 1'b0;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            if (w_out_take) begin
                n_skid_valid = 1'b0;
            end
        end else if (r_dec_valid) begin
            if (!r_out_valid || w_out_take) begin
                w_load_out  = 1'b1;
                n_out_valid = 1'b1;
            end else begin
                w_load_skid  = 1'b1;
                n_skid_valid = 1'b1;
            end
        end else if (w_out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid && w_out_take) begin
            r_out_bits <= r_skid_bits;
            r_out_noch <= r_skid_noch;
        end else if (w_load_out) begin
            r_out_bits <= w_res_bits;
            r_out_noch <= w_res_noch;
        end
        if (w_load_skid) begin
            r_skid_bits <= w_res_bits;
            r_skid_noch <= w_res_noch;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.symbol_bits = r_out_bits;
    assign o_out.no_channel  = r_out_noch;

endmodule
